// ----- design/fcadm_pkg.sv -----
// Package for the four-channel audio DMA mixer core.
// Holds item codes, register offsets, fixed-point constants and the sequencer state type.
// No dependencies.
`timescale 1ns / 1ps

package fcadm_pkg;

	// Kind of an input item, carried on s_tuser
	typedef enum logic [1:0] {
		FUNC_REG  = 2'd0,
		FUNC_DMA  = 2'd1,
		FUNC_MEM  = 2'd2,
		FUNC_TICK = 2'd3
	} func_t;

	// Configuration register indexes
	localparam logic CFG_CPS   = 1'b0;
	localparam logic CFG_COEFF = 1'b1;

	localparam logic [17:0] CPS_RESET   = 18'd20590;
	localparam logic [15:0] COEFF_RESET = 16'd30527;

	// Channel register window and offsets within one channel
	localparam logic [8:0] CH_BASE      = 9'h0A0;
	localparam logic [8:0] CH_TOP       = 9'h0DF;
	localparam logic [3:0] CH_BASE_NIB  = 4'hA;
	localparam logic [3:0] OFF_START_HI = 4'h0;
	localparam logic [3:0] OFF_START_LO = 4'h2;
	localparam logic [3:0] OFF_LEN      = 4'h4;
	localparam logic [3:0] OFF_PER      = 4'h6;
	localparam logic [3:0] OFF_VOL      = 4'h8;

	localparam int DMA_MASTER_BIT = 9;

	// Timing constants, Q8 colour clocks
	localparam logic [19:0] PHASE_PER_LINE = 20'd58240;
	localparam logic [17:0] MIN_CPS        = 18'd16384;
	localparam logic [15:0] MIN_PERIOD     = 16'd124;
	localparam logic [6:0]  VOL_MAX        = 7'd64;
	localparam logic [16:0] FULL_BUFFER    = 17'h10000;

	// Period counter arithmetic width and floor
	localparam int CNT_W = 28;
	localparam logic signed [CNT_W-1:0] COUNTER_MIN = -28'sd33554432;

	localparam logic signed [17:0] OUT_MAX = 18'sd32767;
	localparam logic signed [17:0] OUT_MIN = -18'sd32768;

	// Shared multiplier operand widths
	localparam int MUL_A_W = 35;
	localparam int MUL_B_W = 17;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	typedef enum logic [12:0] {
		S_IDLE    = 13'b0000000000001,
		S_DMA     = 13'b0000000000010,
		S_DMA_LD  = 13'b0000000000100,
		S_PHASE   = 13'b0000000001000,
		S_CHAN    = 13'b0000000010000,
		S_ACC     = 13'b0000000100000,
		S_STEP    = 13'b0000001000000,
		S_FETCH   = 13'b0000010000000,
		S_FILT_L  = 13'b0000100000000,
		S_FILT_L2 = 13'b0001000000000,
		S_FILT_R  = 13'b0010000000000,
		S_FILT_R2 = 13'b0100000000000,
		S_OUT     = 13'b1000000000000
	} state_t;

endpackage

// ----- design/four_channel_audio_dma_mixer_core.sv -----
// Four-channel audio DMA mixer: register, DMA, memory and line-tick items on one stream.
// A DMA write visits every channel and does one memory read per channel that it starts.
// A tick opens up to four samples; each visits every channel and steps the bytes of each playing
// channel, and the block waits while the receiver stalls the output.
// Reset (arst_n low) clears all channel state, filters and phase; memory is not cleared.
// Depends on fcadm_pkg, fcadm_mul and fcadm_sample_mem.
`timescale 1ns / 1ps

module four_channel_audio_dma_mixer_core #(
	parameter int SAMPLE_WORDS = 16384,  // power of two
	parameter int STEP_GUARD   = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [17:0] cfg_data,
	// input items
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // reg_addr[8:0], mem_addr[22:9], data[38:23], zero fill
	input  logic [1:0]  s_tuser,   // func[1:0]
	// result items
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // left[15:0], right[31:16], irq_bits[35:32], zero fill
	output logic        m_tlast
);

	localparam int AW = $clog2(SAMPLE_WORDS);
	localparam int GW = $clog2(STEP_GUARD + 1);
	localparam int CW = fcadm_pkg::CNT_W;

	fcadm_pkg::state_t state_q;

	logic [17:0] cps_q;
	logic [15:0] coeff_q;

	logic [20:0] start_q  [4];
	logic [15:0] len_q    [4];
	logic [15:0] per_q    [4];
	logic [6:0]  vol_q    [4];
	logic [20:0] fp_q     [4];
	logic [16:0] wl_q     [4];
	logic [15:0] held_q   [4];
	logic        lbn_q    [4];
	logic [7:0]  cur_q    [4];
	logic [25:0] pc_q     [4];
	logic        on_q     [4];

	logic [15:0] dma_q;
	logic [15:0] dma_new_q;
	logic [19:0] phase_q;
	logic signed [33:0] fl_q;
	logic signed [33:0] fr_q;

	logic [1:0]  ch_q;
	logic [2:0]  smp_cnt_q;
	logic [GW-1:0] guard_q;
	logic signed [CW-1:0] cnt_q;
	logic signed [16:0] acc_l_q;
	logic signed [16:0] acc_r_q;
	logic [3:0]  irq_q;

	logic        out_valid_q;
	logic [39:0] out_data_q;
	logic        out_last_q;

	// Input fields
	logic [8:0]  in_reg;
	logic [13:0] in_maddr;
	logic [15:0] in_data;
	logic        in_acc;
	logic [1:0]  reg_ch;

	assign in_reg   = s_tdata[8:0];
	assign in_maddr = s_tdata[22:9];
	assign in_data  = s_tdata[38:23];
	assign s_tready = (state_q == fcadm_pkg::S_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign reg_ch   = 2'(in_reg[7:4] - fcadm_pkg::CH_BASE_NIB);

	// Per-channel derived values at the current channel
	logic [15:0] eff_per;
	logic signed [CW-1:0] eff_sh;
	logic [16:0] reload_cnt;
	logic [17:0] cps_eff;
	logic        dma_was, dma_now;
	logic        reload_now;
	logic [20:0] fetch_ptr;
	logic        step_go;
	logic [AW-1:0] mem_raddr;
	logic [15:0] mem_rd;

	assign eff_per    = (per_q[ch_q] < fcadm_pkg::MIN_PERIOD) ? fcadm_pkg::MIN_PERIOD
		: per_q[ch_q];
	assign eff_sh     = CW'({eff_per, 8'h00});
	assign reload_cnt = (len_q[ch_q] == 16'd0) ? fcadm_pkg::FULL_BUFFER : {1'b0, len_q[ch_q]};
	assign cps_eff    = (cps_q < fcadm_pkg::MIN_CPS) ? fcadm_pkg::MIN_CPS : cps_q;
	assign dma_was    = dma_q[fcadm_pkg::DMA_MASTER_BIT] && dma_q[ch_q];
	assign dma_now    = dma_new_q[fcadm_pkg::DMA_MASTER_BIT] && dma_new_q[ch_q];
	assign reload_now = (wl_q[ch_q] <= 17'd1);
	assign fetch_ptr  = reload_now ? start_q[ch_q] : fp_q[ch_q];
	assign step_go    = (cnt_q[CW-1] || cnt_q == '0) && (guard_q < GW'(STEP_GUARD));
	assign mem_raddr  = (state_q == fcadm_pkg::S_DMA) ? AW'(start_q[ch_q][20:1])
		: AW'(fetch_ptr[20:1]);

	fcadm_sample_mem #(.WORDS(SAMPLE_WORDS), .AW(AW)) u_mem (
		.clk   (clk),
		.we    (in_acc && s_tuser == fcadm_pkg::FUNC_MEM),
		.waddr (AW'(in_maddr)),
		.wdata (in_data),
		.raddr (mem_raddr),
		.rdata (mem_rd)
	);

	// Shared multiplier operands
	logic signed [fcadm_pkg::MUL_A_W-1:0] mul_a;
	logic signed [fcadm_pkg::MUL_B_W-1:0] mul_b;
	logic signed [fcadm_pkg::MUL_P_W-1:0] mul_p;
	logic signed [34:0] diff_l, diff_r;

	assign diff_l = $signed({acc_l_q[16], acc_l_q, 17'b0}) - $signed({fl_q[33], fl_q});
	assign diff_r = $signed({acc_r_q[16], acc_r_q, 17'b0}) - $signed({fr_q[33], fr_q});

	always_comb begin
		mul_a = $signed({{27{cur_q[ch_q][7]}}, cur_q[ch_q]});
		mul_b = $signed({10'b0, vol_q[ch_q]});
		case (state_q)
			fcadm_pkg::S_FILT_L: begin
				mul_a = diff_l;
				mul_b = $signed({1'b0, coeff_q});
			end
			fcadm_pkg::S_FILT_R: begin
				mul_a = diff_r;
				mul_b = $signed({1'b0, coeff_q});
			end
			default: begin
			end
		endcase
	end

	fcadm_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (mul_p)
	);

	// Output conversion: truncate toward zero, then clip
	function automatic logic [15:0] to_out16(input logic signed [33:0] f);
		logic signed [33:0] adj;
		logic signed [17:0] t;
		adj = f + (f[33] ? 34'sd65535 : 34'sd0);
		t   = adj[33:16];
		if (t > fcadm_pkg::OUT_MAX) begin
			t = fcadm_pkg::OUT_MAX;
		end else if (t < fcadm_pkg::OUT_MIN) begin
			t = fcadm_pkg::OUT_MIN;
		end
		return t[15:0];
	endfunction

	logic out_free;
	logic smp_last;
	logic signed [CW-1:0] cnt_next;

	assign out_free = !out_valid_q || m_tready;
	assign smp_last = (smp_cnt_q == 3'd3) || (phase_q < 20'(cps_eff));
	assign cnt_next = cnt_q + eff_sh;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cps_q   <= fcadm_pkg::CPS_RESET;
			coeff_q <= fcadm_pkg::COEFF_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				fcadm_pkg::CFG_CPS:   cps_q   <= cfg_data;
				fcadm_pkg::CFG_COEFF: coeff_q <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	// Sequencer and channel state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fcadm_pkg::S_IDLE;
			for (int i = 0; i < 4; i++) begin
				start_q[i] <= '0;
				len_q[i]   <= '0;
				per_q[i]   <= '0;
				vol_q[i]   <= '0;
				fp_q[i]    <= '0;
				wl_q[i]    <= '0;
				held_q[i]  <= '0;
				lbn_q[i]   <= 1'b0;
				cur_q[i]   <= '0;
				pc_q[i]    <= '0;
				on_q[i]    <= 1'b0;
			end
			dma_q       <= '0;
			dma_new_q   <= '0;
			phase_q     <= '0;
			fl_q        <= '0;
			fr_q        <= '0;
			ch_q        <= '0;
			smp_cnt_q   <= '0;
			guard_q     <= '0;
			cnt_q       <= '0;
			acc_l_q     <= '0;
			acc_r_q     <= '0;
			irq_q       <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
			out_last_q  <= 1'b0;
		end else begin
			// drop the result once taken, unless a new one loads now
			if (out_valid_q && m_tready && state_q != fcadm_pkg::S_OUT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				fcadm_pkg::S_IDLE: begin
					if (in_acc) begin
						case (s_tuser)
							fcadm_pkg::FUNC_REG: begin
								if (in_reg >= fcadm_pkg::CH_BASE && in_reg <= fcadm_pkg::CH_TOP) begin
									case (in_reg[3:0])
										fcadm_pkg::OFF_START_HI:
											start_q[reg_ch][20:16] <= in_data[4:0];
										fcadm_pkg::OFF_START_LO:
											start_q[reg_ch][15:0] <= {in_data[15:1], 1'b0};
										fcadm_pkg::OFF_LEN: len_q[reg_ch] <= in_data;
										fcadm_pkg::OFF_PER: per_q[reg_ch] <= in_data;
										fcadm_pkg::OFF_VOL: vol_q[reg_ch] <=
											(in_data[6:0] > fcadm_pkg::VOL_MAX) ? fcadm_pkg::VOL_MAX
											: in_data[6:0];
										default: begin
										end
									endcase
								end
							end
							fcadm_pkg::FUNC_DMA: begin
								dma_new_q <= in_data;
								ch_q      <= '0;
								state_q   <= fcadm_pkg::S_DMA;
							end
							fcadm_pkg::FUNC_TICK: begin
								phase_q   <= phase_q + fcadm_pkg::PHASE_PER_LINE;
								smp_cnt_q <= '0;
								state_q   <= fcadm_pkg::S_PHASE;
							end
							default: begin
							end
						endcase
					end
				end
				// start or silence one channel per pass
				fcadm_pkg::S_DMA: begin
					if (!dma_was && dma_now) begin
						fp_q[ch_q] <= start_q[ch_q] + 21'd2;
						wl_q[ch_q] <= reload_cnt;
						pc_q[ch_q] <= 26'(eff_sh);
						on_q[ch_q] <= 1'b1;
						state_q    <= fcadm_pkg::S_DMA_LD;
					end else begin
						if (dma_was && !dma_now) begin
							on_q[ch_q]  <= 1'b0;
							cur_q[ch_q] <= '0;
						end
						ch_q <= ch_q + 2'd1;
						if (ch_q == 2'd3) begin
							dma_q   <= dma_new_q;
							state_q <= fcadm_pkg::S_IDLE;
						end
					end
				end
				fcadm_pkg::S_DMA_LD: begin
					held_q[ch_q] <= mem_rd;
					cur_q[ch_q]  <= mem_rd[15:8];
					lbn_q[ch_q]  <= 1'b1;
					ch_q         <= ch_q + 2'd1;
					if (ch_q == 2'd3) begin
						dma_q   <= dma_new_q;
						state_q <= fcadm_pkg::S_IDLE;
					end else begin
						state_q <= fcadm_pkg::S_DMA;
					end
				end
				// open the next sample while phase allows and fewer than four are done
				fcadm_pkg::S_PHASE: begin
					if (phase_q >= 20'(cps_eff) && smp_cnt_q < 3'd4) begin
						phase_q <= phase_q - 20'(cps_eff);
						ch_q    <= '0;
						acc_l_q <= '0;
						acc_r_q <= '0;
						irq_q   <= '0;
						state_q <= fcadm_pkg::S_CHAN;
					end else begin
						state_q <= fcadm_pkg::S_IDLE;
					end
				end
				fcadm_pkg::S_CHAN: begin
					if (on_q[ch_q]) begin
						cnt_q   <= $signed({{2{pc_q[ch_q][25]}}, pc_q[ch_q]})
							- $signed(CW'(cps_eff));
						guard_q <= '0;
						state_q <= fcadm_pkg::S_ACC;
					end else begin
						ch_q    <= ch_q + 2'd1;
						state_q <= (ch_q == 2'd3) ? fcadm_pkg::S_FILT_L : fcadm_pkg::S_CHAN;
					end
				end
				fcadm_pkg::S_ACC: begin
					if (ch_q == 2'd0 || ch_q == 2'd3) begin
						acc_l_q <= acc_l_q + mul_p[16:0];
					end else begin
						acc_r_q <= acc_r_q + mul_p[16:0];
					end
					state_q <= fcadm_pkg::S_STEP;
				end
				// advance one byte per pass, or store the counter and go to the next channel
				fcadm_pkg::S_STEP: begin
					if (step_go) begin
						guard_q <= guard_q + GW'(1);
						cnt_q   <= cnt_next;
						if (lbn_q[ch_q]) begin
							lbn_q[ch_q] <= 1'b0;
							cur_q[ch_q] <= held_q[ch_q][7:0];
						end else begin
							if (reload_now) begin
								wl_q[ch_q]  <= reload_cnt;
								irq_q[ch_q] <= 1'b1;
							end else begin
								wl_q[ch_q] <= wl_q[ch_q] - 17'd1;
							end
							fp_q[ch_q] <= fetch_ptr + 21'd2;
							state_q    <= fcadm_pkg::S_FETCH;
						end
					end else begin
						pc_q[ch_q] <= (cnt_q < fcadm_pkg::COUNTER_MIN)
							? 26'(fcadm_pkg::COUNTER_MIN) : cnt_q[25:0];
						ch_q    <= ch_q + 2'd1;
						state_q <= (ch_q == 2'd3) ? fcadm_pkg::S_FILT_L : fcadm_pkg::S_CHAN;
					end
				end
				fcadm_pkg::S_FETCH: begin
					held_q[ch_q] <= mem_rd;
					cur_q[ch_q]  <= mem_rd[15:8];
					lbn_q[ch_q]  <= 1'b1;
					state_q      <= fcadm_pkg::S_STEP;
				end
				fcadm_pkg::S_FILT_L: begin
					state_q <= fcadm_pkg::S_FILT_L2;
				end
				fcadm_pkg::S_FILT_L2: begin
					fl_q    <= fl_q + mul_p[49:16];
					state_q <= fcadm_pkg::S_FILT_R;
				end
				fcadm_pkg::S_FILT_R: begin
					state_q <= fcadm_pkg::S_FILT_R2;
				end
				fcadm_pkg::S_FILT_R2: begin
					fr_q    <= fr_q + mul_p[49:16];
					state_q <= fcadm_pkg::S_OUT;
				end
				// hold until the output register is free
				fcadm_pkg::S_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_data_q  <= {4'b0, irq_q, to_out16(fr_q), to_out16(fl_q)};
						out_last_q  <= smp_last;
						smp_cnt_q   <= smp_cnt_q + 3'd1;
						state_q     <= smp_last ? fcadm_pkg::S_IDLE : fcadm_pkg::S_PHASE;
					end
				end
				default: begin
					state_q <= fcadm_pkg::S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

	// Step count per channel never passes the guard
	a_guard: assert property (@(posedge clk) disable iff (!arst_n)
		guard_q <= GW'(STEP_GUARD))
		else $error("byte step count beyond guard");

	// At most four samples per tick
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == fcadm_pkg::S_OUT) |-> (smp_cnt_q < 3'd4))
		else $error("more than four samples in one tick");

	// A tick keeps the block busy
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && s_tuser == fcadm_pkg::FUNC_TICK) |=> !s_tready)
		else $error("tick accepted without work");

	// A word load always follows a step that issued its read
	a_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == fcadm_pkg::S_FETCH) |-> ($past(state_q) == fcadm_pkg::S_STEP))
		else $error("word load without read");

endmodule

// ----- design/fcadm_sample_mem.sv -----
// Sample memory of the mixer: one write port, one read port with registered data.
// No dependencies.
`timescale 1ns / 1ps

module fcadm_sample_mem #(
	parameter int WORDS = 16384,
	parameter int AW    = 14
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [15:0]   wdata,
	input  logic [AW-1:0] raddr,
	output logic [15:0]   rdata
);

	logic [15:0] mem_q [WORDS];

	// Write and read, read data registered
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- design/fcadm_mul.sv -----
// Shared signed multiplier of the mixer with a registered product.
// Serves both byte times volume and the filter update step.
// Depends on fcadm_pkg.
`timescale 1ns / 1ps

module fcadm_mul (
	input  logic                                 clk,
	input  logic signed [fcadm_pkg::MUL_A_W-1:0] a,
	input  logic signed [fcadm_pkg::MUL_B_W-1:0] b,
	output logic signed [fcadm_pkg::MUL_P_W-1:0] p_q
);

	// Multiply and hold the product for the next step
	always_ff @(posedge clk) begin
		p_q <= fcadm_pkg::MUL_P_W'(a) * fcadm_pkg::MUL_P_W'(b);
	end

endmodule
